/* rtl/ctp_pkg.sv */
`timescale 1ns / 1ps

package ctp_pkg;

	localparam int CAPACITY = 16;
	localparam int OCC_W    = $clog2(CAPACITY + 1);
	localparam int FRAME_W  = 16;
	localparam int COUNT_W  = 5;

	localparam logic [OCC_W-1:0] FULL_OCC = OCC_W'(CAPACITY);

	localparam logic [1:0] OP_CLEAR = 2'd0;
	localparam logic [1:0] OP_ADD   = 2'd1;
	localparam logic [1:0] OP_TICK  = 2'd2;

	typedef struct packed {
		logic [1:0]         operation;
		logic [FRAME_W-1:0] duration;
		logic               blocks_action;
	} item_t;

	typedef struct packed {
		logic [COUNT_W-1:0] expired_count;
		logic [COUNT_W-1:0] active_count;
		logic               blocking_active;
		logic               add_dropped;
	} result_t;

	// commands broadcast to every cell
	typedef struct packed {
		logic               clear;
		logic               tick;
		logic               add;
		logic               shift;
		logic [FRAME_W-1:0] add_frames;
		logic               add_blk;
	} cell_ctrl_t;

	// contents handed from one cell to its neighbour
	typedef struct packed {
		logic               valid;
		logic [FRAME_W-1:0] frames;
		logic               blk;
	} cell_data_t;

endpackage

/* rtl/ctp_cell.sv */
`timescale 1ns / 1ps

module ctp_cell import ctp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cell_ctrl_t ctrl,
	input  logic       prev_valid,
	input  logic       hole_in,
	input  cell_data_t next_data,
	output cell_data_t data,
	output logic       hole_out,
	output logic       dying,
	output logic       blk_now,
	output logic       blk_keep
);

	logic               valid_q;
	logic               blk_q;
	logic [FRAME_W-1:0] frames_q;
	logic               last_frame;
	logic               add_here;

	assign last_frame = (frames_q == FRAME_W'(1));
	assign add_here   = ctrl.add && !valid_q && prev_valid;
	assign hole_out   = hole_in || !valid_q;
	assign dying      = ctrl.tick && valid_q && last_frame;
	assign blk_now    = valid_q && blk_q;
	assign blk_keep   = valid_q && blk_q && !last_frame;
	assign data       = '{valid: valid_q, frames: frames_q, blk: blk_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			blk_q   <= 1'b0;
		end else if (ctrl.clear) begin
			valid_q <= 1'b0;
		end else if (ctrl.tick) begin
			if (valid_q && last_frame) begin
				valid_q <= 1'b0;
			end
		end else if (add_here) begin
			valid_q <= 1'b1;
			blk_q   <= ctrl.add_blk;
		end else if (ctrl.shift && hole_out) begin
			valid_q <= next_data.valid;
			blk_q   <= next_data.blk;
		end
	end

	// frame count carries no reset
	always_ff @(posedge clk) begin
		if (ctrl.tick) begin
			if (valid_q) begin
				frames_q <= frames_q - FRAME_W'(1);
			end
		end else if (add_here && !ctrl.clear) begin
			frames_q <= ctrl.add_frames;
		end else if (ctrl.shift && hole_out && !ctrl.clear) begin
			frames_q <= next_data.frames;
		end
	end

endmodule

/* rtl/countdown_timer_pool.sv */
`timescale 1ns / 1ps
// result: the result of an item is held in the output register in the cycle after its transfer
// throughput: one item per cycle while no result is held under stall, except that a tick which
// leaves gaps among the held timers is followed by compaction, during which items stall, until the
// survivors have closed up through the neighbour-to-neighbour shift of the cell chain
// reset: asynchronous, active low; the pool is empty and no result is pending after reset
module countdown_timer_pool import ctp_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	output logic    item_stall,
	input  item_t   item,
	output logic    result_valid,
	input  logic    result_stall,
	output result_t result
);

	// chain signals, one per cell (the hole chain has one extra link), and the broadcast commands
	cell_data_t            cell_data [CAPACITY];
	logic [CAPACITY:0]     hole_chain;
	logic [CAPACITY-1:0]   dying;
	logic [CAPACITY-1:0]   blk_now;
	logic [CAPACITY-1:0]   blk_keep;
	logic [CAPACITY-1:0]   gap;
	cell_ctrl_t            ctrl;

	logic [OCC_W-1:0]      occ_q;
	logic [OCC_W-1:0]      expired;
	logic [OCC_W-1:0]      occ_next;
	logic                  busy;
	logic                  accept;
	logic                  pool_full;
	logic                  add_ok;
	logic                  add_refused;
	logic                  blocking_next;
	logic                  result_valid_q;
	result_t               result_q;

	// compaction is pending while an empty cell sits below a held one
	assign busy = |gap;

	// a result held under stall blocks the next transfer; one leaving this cycle does not
	assign item_stall = busy || (result_valid_q && result_stall);
	assign accept     = item_valid && !item_stall;

	assign pool_full   = (occ_q >= FULL_OCC);
	assign add_ok      = accept && (item.operation == OP_ADD) &&
	                     (item.duration != '0) && !pool_full;
	assign add_refused = accept && (item.operation == OP_ADD) &&
	                     (item.duration != '0) && pool_full;

	always_comb begin
		ctrl.clear      = accept && (item.operation == OP_CLEAR);
		ctrl.tick       = accept && (item.operation == OP_TICK);
		ctrl.add        = add_ok;
		ctrl.shift      = busy;
		ctrl.add_frames = item.duration;
		ctrl.add_blk    = item.blocks_action;
	end

	assign hole_chain[0] = 1'b0;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic       prev_valid;
		cell_data_t next_data;

		if (i == 0) begin : g_first
			assign prev_valid = 1'b1;
		end else begin : g_inner
			assign prev_valid = cell_data[i-1].valid;
		end

		// the top cell pulls in an empty slot when the chain shifts
		if (i == CAPACITY - 1) begin : g_last
			assign next_data = '{valid: 1'b0, frames: '0, blk: 1'b0};
		end else begin : g_mid
			assign next_data = cell_data[i+1];
		end

		assign gap[i] = !cell_data[i].valid && next_data.valid;

		ctp_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.prev_valid (prev_valid),
			.hole_in    (hole_chain[i]),
			.next_data  (next_data),
			.data       (cell_data[i]),
			.hole_out   (hole_chain[i+1]),
			.dying      (dying[i]),
			.blk_now    (blk_now[i]),
			.blk_keep   (blk_keep[i])
		);
	end

	// timers reaching zero on this tick
	always_comb begin
		expired = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			expired = expired + OCC_W'(dying[i]);
		end
	end

	// pool state after the item, reported in its result
	always_comb begin
		occ_next      = occ_q;
		blocking_next = |blk_now;
		case (item.operation)
			OP_CLEAR: begin
				occ_next      = '0;
				blocking_next = 1'b0;
			end
			OP_ADD: begin
				if (add_ok) begin
					occ_next      = occ_q + OCC_W'(1);
					blocking_next = (|blk_now) || item.blocks_action;
				end
			end
			OP_TICK: begin
				occ_next      = occ_q - expired;
				blocking_next = |blk_keep;
			end
			default: begin
				occ_next      = occ_q;
				blocking_next = |blk_now;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
		end else if (accept) begin
			occ_q <= occ_next;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (accept) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			result_q.expired_count   <= (item.operation == OP_TICK) ?
			                            COUNT_W'(expired) : '0;
			result_q.active_count    <= COUNT_W'(occ_next);
			result_q.blocking_active <= blocking_next;
			result_q.add_dropped     <= add_refused;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

/* verif/testbench.sv */
`timescale 1ns / 1ps

module testbench import ctp_pkg::*; ();

	// the fourth operation code does nothing to the pool
	localparam logic [1:0] OP_NONE = 2'd3;

	// counted items per idling phase, four phases in all
	localparam int PHASE_ITEMS = 363;
	localparam int DIRECTED_ITEMS = 25;

	// output register plus the longest compaction after a tick, with margin
	localparam int SETTLE_CYCLES = CAPACITY + 8;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    item_valid = 1'b0;
	logic    item_stall;
	item_t   item = '0;
	logic    result_valid;
	logic    result_stall = 1'b0;
	result_t result;

	// idling odds in percent, changed only between phases
	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;

	item_t       pending_items[$];
	result_t     awaited_results[$];
	result_t     oldest_awaited;
	int unsigned mismatches = 0;

	// predicted pool contents, in slot order
	logic [FRAME_W-1:0] frames_left[CAPACITY];
	logic               blk_flag[CAPACITY];
	int unsigned        held = 0;

	countdown_timer_pool uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// apply one accepted item to the predicted pool and return the result it gives
	function automatic result_t pool_apply(item_t it);
		result_t     r;
		int unsigned kept;
		int unsigned gone;
		int unsigned i;
		logic [FRAME_W-1:0] left;
		r = '0;
		kept = 0;
		gone = 0;
		case (it.operation)
			OP_CLEAR: begin
				held = 0;
			end
			OP_ADD: begin
				// zero duration is ignored outright, even on a full pool
				if (it.duration != '0) begin
					if (held >= CAPACITY) begin
						r.add_dropped = 1'b1;
					end else begin
						frames_left[held] = it.duration;
						blk_flag[held] = it.blocks_action;
						held++;
					end
				end
			end
			OP_TICK: begin
				// survivors close up towards slot zero, order kept
				for (i = 0; i < held; i++) begin
					left = frames_left[i] - 1'b1;
					if (left == '0) begin
						gone++;
					end else begin
						frames_left[kept] = left;
						blk_flag[kept] = blk_flag[i];
						kept++;
					end
				end
				held = kept;
			end
			default: ;
		endcase
		r.expired_count = COUNT_W'(gone);
		r.active_count = COUNT_W'(held);
		for (i = 0; i < held; i++) begin
			if (blk_flag[i]) begin
				r.blocking_active = 1'b1;
			end
		end
		return r;
	endfunction

	function automatic item_t make_item(logic [1:0] op, logic [FRAME_W-1:0] dur, logic blk);
		item_t it;
		it.operation = op;
		it.duration = dur;
		it.blocks_action = blk;
		return it;
	endfunction

	// append one item to the sender's backlog
	function automatic void enqueue(item_t it);
		pending_items = {pending_items, it};
	endfunction

	// mostly short timers so that expiry is frequent, some long ones to exercise every bit
	function automatic logic [FRAME_W-1:0] pick_duration();
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 70) begin
			return FRAME_W'($urandom_range(1, 6));
		end else if (pick < 80) begin
			return FRAME_W'($urandom_range(7, 40));
		end
		return FRAME_W'($urandom_range(1, 65535));
	endfunction

	function automatic void flag_mismatch(string what, result_t want, result_t got);
		mismatches++;
		if (mismatches <= 10) begin
			$write("%0t: %s: expected expired=%0d active=%0d blocking=%0b dropped=%0b",
				$time, what, want.expired_count, want.active_count, want.blocking_active,
				want.add_dropped);
			$display(", got expired=%0d active=%0d blocking=%0b dropped=%0b",
				got.expired_count, got.active_count, got.blocking_active,
				got.add_dropped);
		end
	endfunction

	// directed opening: empty-pool clear, ignored adds, full pool, dropped add, mass expiry, no-op, clear
	task automatic queue_directed();
		int i;
		enqueue(make_item(OP_CLEAR, 16'hFFFF, 1'b1));
		enqueue(make_item(OP_ADD, '0, 1'b1));
		for (i = 0; i < CAPACITY; i++) begin
			// one long timer without the blocking flag outlives the rest
			if (i == 4) begin
				enqueue(make_item(OP_ADD, 16'hFFFF, 1'b0));
			end else begin
				enqueue(make_item(OP_ADD, FRAME_W'(i % 3 + 1), i[0]));
			end
		end
		enqueue(make_item(OP_ADD, 16'd7, 1'b1));
		enqueue(make_item(OP_ADD, '0, 1'b0));
		repeat (3) enqueue(make_item(OP_TICK, 16'hA5A5, 1'b1));
		enqueue(make_item(OP_NONE, 16'h5A5A, 1'b1));
		enqueue(make_item(OP_CLEAR, '0, 1'b0));
	endtask

	// bursts of adds followed by runs of ticks, with clears and ignored items as noise
	task automatic queue_random(int unsigned target);
		int unsigned counted;
		int unsigned n;
		counted = 0;
		while (counted < target) begin
			n = $urandom_range(1, 20);
			repeat (n) begin
				enqueue(make_item(OP_ADD, pick_duration(), 1'($urandom_range(1))));
			end
			counted += n;
			n = $urandom_range(1, 8);
			repeat (n) begin
				enqueue(make_item(OP_TICK, FRAME_W'($urandom), 1'($urandom_range(1))));
			end
			counted += n;
			case ($urandom_range(9))
				0, 1: begin
					enqueue(make_item(OP_CLEAR, FRAME_W'($urandom),
						1'($urandom_range(1))));
					counted++;
				end
				2: enqueue(make_item(OP_NONE, FRAME_W'($urandom),
					1'($urandom_range(1))));
				3: enqueue(make_item(OP_ADD, '0, 1'($urandom_range(1))));
				default: ;
			endcase
		end
	endtask

	// sender holds off until every transfer has produced its result
	task automatic wait_drained();
		do @(negedge clk);
		while (pending_items.size() != 0 || item_valid || awaited_results.size() != 0);
	endtask

	// driver: predict on each transfer, then present the next item or idle
	always @(posedge clk) begin
		if (arst_n) begin
			if (item_valid && !item_stall) begin
				awaited_results = {awaited_results, pool_apply(item)};
			end
			// a stalled item stays put
			if (!item_valid || !item_stall) begin
				if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					item_valid <= 1'b1;
					item <= pending_items.pop_front();
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: check each result transfer against the oldest prediction
	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid && !result_stall) begin
				if (awaited_results.size() == 0) begin
					flag_mismatch("result with nothing outstanding", '0, result);
				end else begin
					oldest_awaited = awaited_results.pop_front();
					if (result.expired_count !== oldest_awaited.expired_count ||
						result.active_count !== oldest_awaited.active_count ||
						result.blocking_active !== oldest_awaited.blocking_active ||
						result.add_dropped !== oldest_awaited.add_dropped) begin
						flag_mismatch("wrong result", oldest_awaited, result);
					end
				end
			end
			result_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// free-flowing phase, directed items first
		queue_directed();
		queue_random(PHASE_ITEMS - DIRECTED_ITEMS);
		wait_drained();

		// sender idle half the time
		send_idle_pct = 50;
		recv_stall_pct = 0;
		queue_random(PHASE_ITEMS);
		wait_drained();

		// receiver stalling half the time
		send_idle_pct = 0;
		recv_stall_pct = 50;
		queue_random(PHASE_ITEMS);
		wait_drained();

		// light idling on both sides
		send_idle_pct = 8;
		recv_stall_pct = 8;
		queue_random(PHASE_ITEMS);
		wait_drained();

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0 && awaited_results.size() == 0) begin
			$display("countdown_timer_pool: match");
		end else begin
			$display("countdown_timer_pool: mismatch");
		end
		$finish;
	end

	// watchdog, far beyond the slowest correct run
	initial begin
		#5_000_000;
		$display("countdown_timer_pool: mismatch");
		$finish;
	end

endmodule
